@@ rtl/cxpc_pkg.sv @@
// shared types and constants of the chained xor packet cipher
package cxpc_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_KEY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 1'b1;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] PRIVATE_KEY_RESET = 8'd50;

    // direction codes
    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    // final status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_MISMATCH = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] packet_key;
        logic       end_of_packet;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       final_res;
        logic [1:0] status;
    } t_out_item;

    // operands of one chain step
    typedef struct packed {
        logic       decrypt;
        logic [7:0] data;
        logic [7:0] held_key;
        logic [7:0] private_key;
        logic [7:0] index;
        logic [7:0] prev_inner;
        logic [7:0] prev_outer;
    } t_chain_in;

    // result of one chain step and the chain values it leaves
    typedef struct packed {
        logic [7:0] res;
        logic [7:0] inner;
        logic [7:0] outer;
    } t_chain_out;

    typedef enum logic [1:0] {
        ST_IN,
        ST_FETCH,
        ST_EMIT
    } t_state;

endpackage

@@ rtl/cxpc_ram.sv @@
// generic single-write, single-read ram with registered read data
module cxpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    i_clk,
    i_we,
    i_waddr,
    i_wdata,
    i_re,
    i_raddr,
    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             i_clk;
    input  logic             i_we;
    input  logic [AW-1:0]    i_waddr;
    input  logic [WIDTH-1:0] i_wdata;
    input  logic             i_re;
    input  logic [AW-1:0]    i_raddr;
    output logic [WIDTH-1:0] o_rdata;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cxpc_chain.sv @@
// one step of the two-stage xor chain, encrypt or decrypt
module cxpc_chain (
    i_op,
    o_res
);
    import cxpc_pkg::*;

    input  cxpc_pkg::t_chain_in  i_op;
    output cxpc_pkg::t_chain_out o_res;

    logic [7:0] step;
    logic [7:0] inner_pad;
    logic [7:0] outer_pad;
    logic [7:0] mid;

    always_comb begin
        step      = i_op.index + 8'd1;
        inner_pad = i_op.held_key + step + i_op.prev_inner;
        outer_pad = i_op.private_key + step + i_op.prev_outer;
        if (i_op.decrypt) begin
            // peel the outer layer first
            mid         = i_op.data ^ outer_pad;
            o_res.res   = mid ^ inner_pad;
            o_res.inner = mid;
            o_res.outer = i_op.data;
        end else begin
            mid         = i_op.data ^ inner_pad;
            o_res.res   = mid ^ outer_pad;
            o_res.inner = mid;
            o_res.outer = mid ^ outer_pad;
        end
    end

endmodule

@@ rtl/chained_xor_packet_cipher_unit.sv @@
// top level of the chained xor packet cipher
// Packet cipher working on one byte per beat, one packet at a time. In encrypt
// mode the payload bytes are written into a MAX_PAYLOAD-entry ram and summed;
// bytes beyond the ram size are dropped and flagged. After the beat that
// carries end_of_packet the block stalls its input while it emits the
// encrypted checksum followed by the encrypted payload: each payload byte is
// read from the ram in ST_FETCH and put through the chain step into the
// output register in ST_EMIT, and the input opens again after the last byte.
// In decrypt mode every byte is decrypted in the beat it is accepted and goes
// to the output register; a byte can enter every cycle as long as the output
// side keeps taking beats. The first decrypted byte of a packet is the
// checksum and gives no beat unless the packet is that single byte, then a
// status-only beat. The final beat of a packet carries the status: ok,
// checksum mismatch or overflow. Configuration is written through a plain
// write port: index 0 private key, index 1 direction.
module chained_xor_packet_cipher_unit #(
    parameter int MAX_PAYLOAD = 63
) (
    i_clk,
    i_rst_n,
    i_in_valid,
    o_in_stall,
    i_in_data,
    o_out_valid,
    i_out_stall,
    o_out_data,
    i_cfg_we,
    i_cfg_index,
    i_cfg_wdata
);
    import cxpc_pkg::*;

    localparam int AW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int BCW = $clog2(MAX_PAYLOAD + 1);

    input  logic                           i_clk;
    input  logic                           i_rst_n;
    input  logic                           i_in_valid;
    output logic                           o_in_stall;
    input  cxpc_pkg::t_in_item             i_in_data;
    output logic                           o_out_valid;
    input  logic                           i_out_stall;
    output cxpc_pkg::t_out_item            o_out_data;
    input  logic                           i_cfg_we;
    input  logic [cxpc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    input  logic [cxpc_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    // control and chain state
    t_state         r_state, n_state;
    logic           r_in_packet, n_in_packet;
    logic [7:0]     r_held_key, n_held_key;
    logic [BCW-1:0] r_cnt, n_cnt;
    logic [7:0]     r_sum, n_sum;
    logic [7:0]     r_pin, n_pin;
    logic [7:0]     r_pout, n_pout;
    logic [7:0]     r_idx, n_idx;
    logic [7:0]     r_sent, n_sent;
    logic           r_ovf, n_ovf;
    logic [BCW-1:0] r_pos, n_pos;

    // configuration
    logic [7:0]     r_pkey;
    logic           r_dir;

    // output register
    logic           r_out_valid, n_out_valid;
    t_out_item      r_out_data, n_out_data;

    // ram ports
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;

    t_chain_in      chain_op;
    t_chain_out     chain_res;

    logic           out_free;
    logic           in_acc;
    logic           first;
    logic [7:0]     sum_new;
    logic [BCW-1:0] pos_m1;
    logic           drain_last;

    cxpc_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PAYLOAD)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_in_data.data_byte),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    cxpc_chain u_chain (
        .i_op (chain_op),
        .o_res(chain_res)
    );

    // output register can load when empty or being drained this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IN) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign first      = !r_in_packet;
    assign pos_m1     = r_pos - BCW'(1);
    assign drain_last = (r_pos == r_cnt);

    // chain operands: the input beat in ST_IN, the stored packet while draining
    always_comb begin
        chain_op.private_key = r_pkey;
        if (r_state == ST_IN) begin
            chain_op.decrypt = r_dir;
            chain_op.data    = i_in_data.data_byte;
            if (first) begin
                chain_op.held_key   = i_in_data.packet_key;
                chain_op.index      = 8'd0;
                chain_op.prev_inner = 8'd0;
                chain_op.prev_outer = 8'd0;
            end else begin
                chain_op.held_key   = r_held_key;
                chain_op.index      = r_idx;
                chain_op.prev_inner = r_pin;
                chain_op.prev_outer = r_pout;
            end
        end else begin
            chain_op.decrypt    = DIR_ENCRYPT;
            // position zero is the checksum, the rest come from the ram
            chain_op.data       = (r_pos == '0) ? r_sum : ram_rdata;
            chain_op.held_key   = r_held_key;
            chain_op.index      = r_idx;
            chain_op.prev_inner = r_pin;
            chain_op.prev_outer = r_pout;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_in_packet = r_in_packet;
        n_held_key  = r_held_key;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_pin       = r_pin;
        n_pout      = r_pout;
        n_idx       = r_idx;
        n_sent      = r_sent;
        n_ovf       = r_ovf;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_cnt[AW-1:0];
        ram_re      = 1'b0;
        ram_raddr   = pos_m1[AW-1:0];
        sum_new     = r_sum;

        case (r_state)
            ST_IN: begin
                if (in_acc) begin
                    // a new packet starts from cleared chain state
                    if (first) begin
                        n_held_key = i_in_data.packet_key;
                        n_cnt      = '0;
                        n_sum      = 8'd0;
                        n_pin      = 8'd0;
                        n_pout     = 8'd0;
                        n_idx      = 8'd0;
                        n_ovf      = 1'b0;
                        ram_waddr  = '0;
                    end
                    n_in_packet = !i_in_data.end_of_packet;
                    if (r_dir == DIR_ENCRYPT) begin
                        if ((first ? BCW'(0) : r_cnt) < BCW'(MAX_PAYLOAD)) begin
                            ram_we = 1'b1;
                            n_cnt  = (first ? BCW'(0) : r_cnt) + BCW'(1);
                            n_sum  = (first ? 8'd0 : r_sum) + i_in_data.data_byte;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (i_in_data.end_of_packet) begin
                            // drain restarts the chain from zero
                            n_in_packet = 1'b1;
                            n_pin       = 8'd0;
                            n_pout      = 8'd0;
                            n_idx       = 8'd0;
                            n_pos       = '0;
                            n_state     = ST_EMIT;
                        end
                    end else begin
                        n_pin = chain_res.inner;
                        n_pout = chain_res.outer;
                        n_idx = (first ? 8'd0 : r_idx) + 8'd1;
                        if (first) begin
                            n_sent = chain_res.res;
                            if (i_in_data.end_of_packet) begin
                                // checksum-only packet
                                n_out_valid           = 1'b1;
                                n_out_data.out_byte   = 8'd0;
                                n_out_data.byte_valid = 1'b0;
                                n_out_data.final_res  = 1'b1;
                                n_out_data.status     = (chain_res.res == 8'd0) ?
                                                        STAT_OK : STAT_MISMATCH;
                            end
                        end else begin
                            sum_new               = r_sum + chain_res.res;
                            n_sum                 = sum_new;
                            n_out_valid           = 1'b1;
                            n_out_data.out_byte   = chain_res.res;
                            n_out_data.byte_valid = 1'b1;
                            n_out_data.final_res  = i_in_data.end_of_packet;
                            n_out_data.status     = STAT_OK;
                            if (i_in_data.end_of_packet && (sum_new != r_sent)) begin
                                n_out_data.status = STAT_MISMATCH;
                            end
                        end
                    end
                end
            end
            ST_FETCH: begin
                // read the payload byte for the current position
                ram_re  = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_data.out_byte   = chain_res.res;
                    n_out_data.byte_valid = 1'b1;
                    n_out_data.final_res  = drain_last;
                    n_out_data.status     = (drain_last && r_ovf) ? STAT_OVERFLOW : STAT_OK;
                    n_pin                 = chain_res.inner;
                    n_pout                = chain_res.outer;
                    n_idx                 = r_idx + 8'd1;
                    if (drain_last) begin
                        n_in_packet = 1'b0;
                        n_state     = ST_IN;
                    end else begin
                        n_pos   = r_pos + BCW'(1);
                        n_state = ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = ST_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IN;
            r_in_packet <= 1'b0;
            r_held_key  <= 8'd0;
            r_cnt       <= '0;
            r_sum       <= 8'd0;
            r_pin       <= 8'd0;
            r_pout      <= 8'd0;
            r_idx       <= 8'd0;
            r_sent      <= 8'd0;
            r_ovf       <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_packet <= n_in_packet;
            r_held_key  <= n_held_key;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_pin       <= n_pin;
            r_pout      <= n_pout;
            r_idx       <= n_idx;
            r_sent      <= n_sent;
            r_ovf       <= n_ovf;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload needs no reset
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkey <= PRIVATE_KEY_RESET;
            r_dir  <= DIR_ENCRYPT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRIVATE_KEY: r_pkey <= i_cfg_wdata[7:0];
                CFG_DIRECTION:   r_dir  <= i_cfg_wdata[0];
                default:         r_pkey <= r_pkey;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ rtl/cxpc_checker.sv @@
// port-level checker for the chained xor packet cipher and its bind
module cxpc_checker (
    i_clk,
    i_rst_n,
    o_out_valid,
    i_out_stall,
    o_out_data
);
    import cxpc_pkg::*;

    input logic                i_clk;
    input logic                i_rst_n;
    input logic                o_out_valid;
    input logic                i_out_stall;
    input cxpc_pkg::t_out_item o_out_data;

    // a stalled result beat stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // only the final beat of a packet carries a status
    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.final_res |-> o_out_data.status == STAT_OK)
        else $error("status on a non-final beat");

    // a status-only beat closes the packet and carries a zero byte
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.byte_valid |->
            o_out_data.final_res && o_out_data.out_byte == 8'd0)
        else $error("status-only beat is not final or carries data");

    // the status code is one of the defined values
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status == STAT_OK ||
            o_out_data.status == STAT_MISMATCH || o_out_data.status == STAT_OVERFLOW)
        else $error("undefined status code");

endmodule

bind chained_xor_packet_cipher_unit cxpc_checker u_cxpc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
